/* src/bmhq_pkg.sv */
// Shared types, constants and the key order function of the binary min heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index of the deepest slot: 2 * (CAPACITY - 1) + 2
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int STAT_W   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wa;
        logic [KEY_W-1:0]  wd;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] removed_key;
        logic [CNT_W-1:0] entry_count;
        status_t          status;
    } res_t;

    // true when a must sit below b in the heap
    function automatic logic worse(input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b,
                                   input logic             max_first);
        worse = max_first ? (a < b) : (a > b);
    endfunction

endpackage

/* src/bmhq_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra,
    input  logic [AW-1:0]    rb,
    output logic [WIDTH-1:0] qa,
    output logic [WIDTH-1:0] qb
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] qa_reg;
    logic [WIDTH-1:0] qb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        qa_reg <= mem[ra];
        qb_reg <= mem[rb];
    end

    assign qa = qa_reg;
    assign qb = qb_reg;

endmodule

/* src/bmhq_ctrl.sv */
// Sift engine: walks the heap one level per step through the RAM, hole-based moves.
module bmhq_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               max_first,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [bmhq_pkg::KEY_W-1:0]         key,
    output logic                               res_valid,
    input  logic                               res_ready,
    output bmhq_pkg::res_t                     res,
    output bmhq_pkg::mem_req_t                 mem_req,
    input  logic [bmhq_pkg::KEY_W-1:0]         qa,
    input  logic [bmhq_pkg::KEY_W-1:0]         qb
);

    typedef enum logic [2:0] {
        IDLE,
        UP_RD,
        UP_CMP,
        DN_RD0,
        DN_LD,
        DN_RD,
        DN_CMP,
        DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [bmhq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [bmhq_pkg::ADDR_W-1:0]   pos_reg, pos_next;
    logic [bmhq_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [bmhq_pkg::KEY_W-1:0]    rem_reg, rem_next;
    bmhq_pkg::status_t             status_reg, status_next;

    logic [bmhq_pkg::ADDR_W-1:0]   parent;
    logic [bmhq_pkg::CHILD_W-1:0]  child_l;
    logic [bmhq_pkg::CHILD_W-1:0]  child_r;
    logic [bmhq_pkg::CHILD_W-1:0]  n_ext;
    logic                          take_r;
    logic [bmhq_pkg::KEY_W-1:0]    pick_val;
    logic [bmhq_pkg::ADDR_W-1:0]   pick_idx;

    assign parent  = (pos_reg - bmhq_pkg::ADDR_W'(1)) >> 1;
    assign child_l = {1'b0, pos_reg, 1'b1};
    assign child_r = child_l + bmhq_pkg::CHILD_W'(1);
    assign n_ext   = bmhq_pkg::CHILD_W'(count_reg);
    // ties go right: left wins only when strictly better
    assign take_r   = (child_r < n_ext) && !bmhq_pkg::worse(qb, qa, max_first);
    assign pick_val = take_r ? qb : qa;
    assign pick_idx = take_r ? child_r[bmhq_pkg::ADDR_W-1:0]
                             : child_l[bmhq_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        mem_req.we  = 1'b0;
        mem_req.wa  = pos_reg;
        mem_req.wd  = key_reg;
        mem_req.ra  = '0;
        mem_req.rb  = '0;

        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    rem_next    = '0;
                    status_next = bmhq_pkg::ST_OK;
                    if (opcode == bmhq_pkg::OP_INSERT)
                    begin
                        if (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
                        begin
                            status_next = bmhq_pkg::ST_FULL;
                            state_next  = DONE;
                        end
                        else
                        begin
                            key_next   = key;
                            pos_next   = count_reg[bmhq_pkg::ADDR_W-1:0];
                            count_next = count_reg + bmhq_pkg::CNT_W'(1);
                            state_next = UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bmhq_pkg::ST_EMPTY;
                            state_next  = DONE;
                        end
                        else
                        begin
                            count_next = count_reg - bmhq_pkg::CNT_W'(1);
                            state_next = DN_RD0;
                        end
                    end
                end
            end
            UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.we = 1'b1;
                    state_next = DONE;
                end
                else
                begin
                    mem_req.ra = parent;
                    state_next = UP_CMP;
                end
            end
            UP_CMP:
            begin
                mem_req.we = 1'b1;
                if (bmhq_pkg::worse(qa, key_reg, max_first))
                begin
                    // parent moves down into the hole
                    mem_req.wd = qa;
                    pos_next   = parent;
                    state_next = UP_RD;
                end
                else
                begin
                    state_next = DONE;
                end
            end
            DN_RD0:
            begin
                mem_req.ra = '0;
                mem_req.rb = count_reg[bmhq_pkg::ADDR_W-1:0];
                state_next = DN_LD;
            end
            DN_LD:
            begin
                rem_next = qa;
                key_next = qb;
                pos_next = '0;
                state_next = (count_reg == '0) ? DONE : DN_RD;
            end
            DN_RD:
            begin
                if (child_l >= n_ext)
                begin
                    mem_req.we = 1'b1;
                    state_next = DONE;
                end
                else
                begin
                    mem_req.ra = child_l[bmhq_pkg::ADDR_W-1:0];
                    mem_req.rb = child_r[bmhq_pkg::ADDR_W-1:0];
                    state_next = DN_CMP;
                end
            end
            DN_CMP:
            begin
                mem_req.we = 1'b1;
                if (bmhq_pkg::worse(key_reg, pick_val, max_first))
                begin
                    mem_req.wd = pick_val;
                    pos_next   = pick_idx;
                    state_next = DN_RD;
                end
                else
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (res_ready)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            count_reg  <= '0;
            status_reg <= bmhq_pkg::ST_OK;
            pos_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
        end
    end

    assign in_ready        = (state_reg == IDLE);
    assign res_valid       = (state_reg == DONE);
    assign res.removed_key = rem_reg;
    assign res.entry_count = count_reg;
    assign res.status      = status_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        else $error("held count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (bmhq_pkg::CNT_W'(mem_req.wa) < count_reg))
        else $error("write outside the live heap");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=> $stable(count_reg))
        else $error("count changed without a request");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == bmhq_pkg::OP_REMOVE && count_reg == '0)
        |=> (res_valid && status_reg == bmhq_pkg::ST_EMPTY))
        else $error("remove on empty not flagged");
`endif

endmodule

/* src/binary_min_heap_queue_top.sv */
// Top level of the binary heap priority queue: key order register, engine, RAM, result register.
// One request at a time. An insert walks up one level per step as the key climbs;
// a remove first reads the root and the last entry, then walks down one level per step as
// the moved entry sinks. Each level costs one RAM read and one compare-and-write.
// A new request is taken while the previous result still waits in the output register.
// Inserts into a full heap return status 1, removes from an empty heap status 2.
module binary_min_heap_queue_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [bmhq_pkg::KEY_W-1:0]         key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bmhq_pkg::KEY_W-1:0]         removed_key,
    output logic [bmhq_pkg::CNT_W-1:0]         entry_count,
    output logic [bmhq_pkg::STAT_W-1:0]        status
);

    logic                        max_first_reg;
    logic                        out_valid_reg;
    bmhq_pkg::res_t              out_reg;
    logic                        res_valid;
    logic                        res_ready;
    bmhq_pkg::res_t              res;
    bmhq_pkg::mem_req_t          mem_req;
    logic [bmhq_pkg::KEY_W-1:0]  qa;
    logic [bmhq_pkg::KEY_W-1:0]  qb;

    assign res_ready = !out_valid_reg || out_ready;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_first (max_first_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key       (key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .qa        (qa),
        .qb        (qb)
    );

    bmhq_ram #(
        .WIDTH (bmhq_pkg::KEY_W),
        .DEPTH (bmhq_pkg::CAPACITY)
    ) u_ram (
        .clk (clk),
        .we  (mem_req.we),
        .wa  (mem_req.wa),
        .wd  (mem_req.wd),
        .ra  (mem_req.ra),
        .rb  (mem_req.rb),
        .qa  (qa),
        .qb  (qb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_first_reg <= cfg_wr_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign removed_key = out_reg.removed_key;
    assign entry_count = out_reg.entry_count;
    assign status      = out_reg.status;

endmodule

/* sim/tb_binary_min_heap_queue_top.sv */
// Self-checking testbench for the binary heap priority queue: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_binary_min_heap_queue_top;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_ROWS    = 25;

    typedef struct packed {
        logic                       op;
        logic [bmhq_pkg::KEY_W-1:0] req_key;
        logic                       fixed;
        bmhq_pkg::res_t             result;
    } dir_row_t;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic                        cfg_wr_data = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic                        opcode      = bmhq_pkg::OP_INSERT;
    logic [bmhq_pkg::KEY_W-1:0]  key         = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [bmhq_pkg::KEY_W-1:0]  removed_key;
    logic [bmhq_pkg::CNT_W-1:0]  entry_count;
    logic [bmhq_pkg::STAT_W-1:0] status;

    // predictor state
    logic [bmhq_pkg::KEY_W-1:0] heap_keys [bmhq_pkg::CAPACITY];
    int unsigned      heap_len   = 0;
    logic             order_max  = 1'b0;

    bmhq_pkg::res_t   pending_results [$];
    int               fail_count    = 0;
    int               cycle_count   = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    // directed rows: fixed results only where obvious
    dir_row_t dir_rows [NUM_ROWS] = '{
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, 11'd0, bmhq_pkg::ST_EMPTY}},
        '{bmhq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'h0, 11'd1, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0, 11'd2, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, 11'd1, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, 11'd0, bmhq_pkg::ST_EMPTY}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0003, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0009, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h0000_0007, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        // key is ignored on remove
        '{bmhq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '{32'h0, 11'd0, bmhq_pkg::ST_OK}},
        '{bmhq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, 11'd0, bmhq_pkg::ST_EMPTY}}
    };

    binary_min_heap_queue_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .removed_key (removed_key),
        .entry_count (entry_count),
        .status      (status)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic sits_below(input logic [bmhq_pkg::KEY_W-1:0] a,
                                        input logic [bmhq_pkg::KEY_W-1:0] b);
        return order_max ? (a < b) : (a > b);
    endfunction

    task automatic swap_keys(input int unsigned a, input int unsigned b);
        logic [bmhq_pkg::KEY_W-1:0] tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endtask

    task automatic apply_heap_op(input logic op, input logic [bmhq_pkg::KEY_W-1:0] k,
                                 output bmhq_pkg::res_t r);
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned rc;
        int unsigned pick;
        bit          done;
        r = '{removed_key: '0, entry_count: '0, status: bmhq_pkg::ST_OK};
        if (op == bmhq_pkg::OP_INSERT)
        begin
            if (heap_len >= bmhq_pkg::CAPACITY)
            begin
                r.status = bmhq_pkg::ST_FULL;
            end
            else
            begin
                pos = heap_len;
                heap_keys[pos] = k;
                done = 1'b0;
                while (pos > 0 && !done)
                begin
                    up = (pos - 1) / 2;
                    if (!sits_below(heap_keys[up], heap_keys[pos]))
                        done = 1'b1;
                    else
                    begin
                        swap_keys(up, pos);
                        pos = up;
                    end
                end
                heap_len++;
            end
        end
        else if (heap_len == 0)
        begin
            r.status = bmhq_pkg::ST_EMPTY;
        end
        else
        begin
            r.removed_key = heap_keys[0];
            heap_keys[0] = heap_keys[heap_len - 1];
            heap_len--;
            pos = 0;
            done = 1'b0;
            while (!done)
            begin
                lc = pos * 2 + 1;
                rc = pos * 2 + 2;
                if (lc >= heap_len)
                    done = 1'b1;
                else
                begin
                    pick = lc;
                    // ties go to the right child
                    if (rc < heap_len)
                        pick = sits_below(heap_keys[rc], heap_keys[lc]) ? lc : rc;
                    if (!sits_below(heap_keys[pos], heap_keys[pick]))
                        done = 1'b1;
                    else
                    begin
                        swap_keys(pos, pick);
                        pos = pick;
                    end
                end
            end
        end
        r.entry_count = heap_len[bmhq_pkg::CNT_W-1:0];
    endtask

    // drive one request and record its expected result on acceptance
    task automatic send_request(input logic op, input logic [bmhq_pkg::KEY_W-1:0] k,
                                input logic fixed, input bmhq_pkg::res_t fixed_res);
        bmhq_pkg::res_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_heap_op(op, k, predicted);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_order(input logic mf);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mf;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        order_max   = mf;
    endtask

    // mix of tie-prone small keys, extremes and full-range keys
    function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel < 2)
            return bmhq_pkg::KEY_W'($urandom_range(7));
        else if (sel == 2)
            return $urandom_range(1) ? '1 : '0;
        else
            return bmhq_pkg::KEY_W'($urandom);
    endfunction

    task automatic send_random(input int insert_pct);
        bmhq_pkg::res_t no_res;
        no_res = '{removed_key: '0, entry_count: '0, status: bmhq_pkg::ST_OK};
        send_request(($urandom_range(99) < insert_pct) ? bmhq_pkg::OP_INSERT
                                                       : bmhq_pkg::OP_REMOVE,
                     rand_key(), 1'b0, no_res);
    endtask

    // result checker and receiver back-pressure
    always @(posedge clk)
    begin
        bmhq_pkg::res_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: removed_key %h entry_count %0d status %0d",
                       removed_key, entry_count, status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (removed_key !== want.removed_key)
                begin
                    $error("removed_key: expected %h, actual %h", want.removed_key, removed_key);
                    fail_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 86;
        write_order(1'b0);
        for (int i = 0; i < NUM_ROWS; i++)
            send_request(dir_rows[i].op, dir_rows[i].req_key, dir_rows[i].fixed,
                         dir_rows[i].result);

        // phase 1: smallest first, mostly inserts
        for (int i = 0; i < 350; i++)
            send_random(95);

        // phase 2: largest first over the old layout, fill to capacity, then churn at full
        write_order(1'b1);
        send_idle_pct = 86;
        recv_idle_pct = 25;
        n = 0;
        while (heap_len < bmhq_pkg::CAPACITY && n < 1100)
        begin
            send_random(99);
            n++;
        end
        for (int i = 0; i < 40; i++)
            send_random(75);

        // phase 3: smallest first again, no idling, remove-heavy
        write_order(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 120; i++)
            send_random(40);

        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
